// ===== src/cross_neighbourhood_max_filter_core_defines.svh =====
// assertion macros for the cross neighbourhood max filter
// expects signals named clock and reset in the scope of each use
`ifndef CROSS_NEIGHBOURHOOD_MAX_FILTER_CORE_DEFINES_SVH
`define CROSS_NEIGHBOURHOOD_MAX_FILTER_CORE_DEFINES_SVH

// checked only outside reset
`define CNMF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define CNMF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/cnmf_pkg.sv =====
// shared types and constants of the cross neighbourhood max filter
// no dependencies
package cnmf_pkg;

   localparam int ELEMENT_WIDTH = 16;
   localparam int RESULT_WIDTH  = 15;
   localparam int CFG_WIDTH     = 8;
   localparam int RESET_SIZE    = 8;

   typedef enum logic [0:0] {
      KIND_ELEMENT = 1'b0,
      KIND_DRAIN   = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                        kind;
      logic signed [ELEMENT_WIDTH-1:0] element;
   } req_type;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] result_value;
      logic                    frame_last;
   } rsp_type;

   // one line buffer entry: the row before last and the last row at a column
   typedef struct packed {
      logic signed [ELEMENT_WIDTH-1:0] older;
      logic signed [ELEMENT_WIDTH-1:0] recent;
   } line_word_type;

   // per-item control from the raster sequencer to the compute stage
   typedef struct packed {
      logic is_element;
      logic emit;
      logic has_up;
      logic has_left;
      logic has_right;
      logic last;
   } ctrl_type;

endpackage

// ===== src/cnmf_ram.sv =====
// generic ram: one write port, two read ports with registered read data
// no dependencies
module cnmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== src/cnmf_ctrl.sv =====
// raster and drain sequencer: size register, row/column/drain counters,
// per-item control and line buffer address; uses cnmf_pkg
module cnmf_ctrl import cnmf_pkg::*; #(
   parameter int MAX_SIZE = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CFG_WIDTH-1:0]        csr_wdata,
   input  logic                        accept,
   input  kind_type                    kind,
   output ctrl_type                    item_ctrl,
   output logic [$clog2(MAX_SIZE)-1:0] item_addr,
   output logic [$clog2(MAX_SIZE)-1:0] item_addr_next
);

   localparam int AW = $clog2(MAX_SIZE);
   localparam int NW = $clog2(MAX_SIZE + 1);

   logic [NW-1:0] n_ff, n_in;
   logic [AW-1:0] row_ff, row_in;
   logic [AW-1:0] col_ff, col_in;
   logic [NW-1:0] drain_ff, drain_in;

   logic          wrap;
   logic [AW-1:0] r, c;
   logic [NW-1:0] r_next, c_next;
   logic          d_pend;
   logic [NW-1:0] d, d_next;

   always_comb begin
      // a stale position outside the matrix restarts the frame
      wrap      = (NW'(row_ff) >= n_ff) || (NW'(col_ff) >= n_ff);
      r         = wrap ? '0 : row_ff;
      c         = wrap ? '0 : col_ff;
      c_next    = NW'(c) + NW'(1);
      r_next    = NW'(r) + NW'(1);
      d_pend    = (drain_ff != '0) && (drain_ff <= n_ff);
      d         = n_ff - drain_ff;
      d_next    = d + NW'(1);
      item_ctrl = '0;
      item_addr = c;
      unique case (kind)
         KIND_ELEMENT: begin
            item_ctrl.is_element = 1'b1;
            item_ctrl.emit       = (r != '0);
            item_ctrl.has_up     = (NW'(r) > NW'(1));
            item_ctrl.has_left   = (c != '0);
            item_ctrl.has_right  = (c_next < n_ff);
            item_addr            = c;
         end
         KIND_DRAIN: begin
            item_ctrl.emit       = d_pend;
            item_ctrl.has_up     = (n_ff > NW'(1));
            item_ctrl.has_left   = (d != '0);
            item_ctrl.has_right  = (d_next < n_ff);
            item_ctrl.last       = (drain_ff == NW'(1));
            item_addr            = d[AW-1:0];
         end
         default: begin
            item_addr = c;
         end
      endcase
      item_addr_next = item_addr + AW'(1);
   end

   always_comb begin
      n_in     = n_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      drain_in = drain_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            n_in = NW'(1);
         end else if (32'(csr_wdata) > 32'(MAX_SIZE)) begin
            n_in = NW'(MAX_SIZE);
         end else begin
            n_in = NW'(csr_wdata);
         end
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
      end else if (accept) begin
         unique case (kind)
            KIND_ELEMENT: begin
               drain_in = '0;
               if (c_next == n_ff) begin
                  col_in = '0;
                  if (r_next == n_ff) begin
                     row_in   = '0;
                     drain_in = n_ff;
                  end else begin
                     row_in = r_next[AW-1:0];
                  end
               end else begin
                  row_in = r;
                  col_in = c_next[AW-1:0];
               end
            end
            KIND_DRAIN: begin
               if (d_pend) begin
                  drain_in = drain_ff - NW'(1);
               end
            end
            default: begin
               drain_in = drain_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= NW'((MAX_SIZE < RESET_SIZE) ? MAX_SIZE : RESET_SIZE);
         row_ff   <= '0;
         col_ff   <= '0;
         drain_ff <= '0;
      end else begin
         n_ff     <= n_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         drain_ff <= drain_in;
      end
   end

endmodule

// ===== src/cross_neighbourhood_max_filter_core.sv =====
// channel  | signals                       | beat taken when
// ---------+-------------------------------+---------------------------
// request  | req_valid, req_stall, req_data | req_valid && !req_stall
// response | rsp_valid, rsp_stall, rsp_data | rsp_valid && !rsp_stall
// csr      | csr_we, csr_wdata              | csr_we (matrix size)
//
// one beat per cycle while req_stall is low; the line buffer ram is read at
// acceptance and the max is formed in the s1 stage, which writes back and
// loads rsp_valid_ff when the response is free; one ram write per element beat
// same-entry read/write overlap between adjacent beats is forwarded
// synchronous reset clears counters and valids, no clearing pass on the ram
// a stalled response holds one result and one in flight before req_stall
// uses cnmf_pkg, cnmf_ctrl, cnmf_ram
module cross_neighbourhood_max_filter_core import cnmf_pkg::*; #(
   parameter int MAX_SIZE = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CFG_WIDTH-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_SIZE);
   localparam int EW = ELEMENT_WIDTH;

   function automatic logic signed [EW-1:0] smax(input logic signed [EW-1:0] a,
                                                 input logic signed [EW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   logic          accept, out_ready, s1_fire;
   ctrl_type      item_ctrl;
   logic [AW-1:0] item_addr, item_addr_next;

   logic                 wr_en;
   line_word_type        wr_data;
   line_word_type        rd_a, rd_b;

   logic                 s1_valid_ff;
   ctrl_type             s1_ctrl_ff;
   logic [AW-1:0]        s1_addr_ff;
   logic signed [EW-1:0] s1_elem_ff;
   logic                 byp_a_hit_ff;
   line_word_type        byp_a_data_ff;
   logic                 byp_b_hit_ff;
   logic signed [EW-1:0] byp_b_data_ff;
   logic signed [EW-1:0] left_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   line_word_type        word_a;
   logic signed [EW-1:0] center_v, up_v, left_v, right_v, elem_v, m;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   cnmf_ctrl #(
      .MAX_SIZE(MAX_SIZE)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .accept         (accept),
      .kind           (req_data.kind),
      .item_ctrl      (item_ctrl),
      .item_addr      (item_addr),
      .item_addr_next (item_addr_next)
   );

   cnmf_ram #(
      .WIDTH($bits(line_word_type)),
      .DEPTH(MAX_SIZE)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (s1_addr_ff),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (item_addr),
      .rd_addr_b (item_addr_next),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // compute stage
   always_comb begin
      word_a   = byp_a_hit_ff ? byp_a_data_ff : rd_a;
      center_v = word_a.recent;
      // neighbours outside the matrix fall back to the zero floor
      up_v    = s1_ctrl_ff.has_up     ? word_a.older : '0;
      left_v  = s1_ctrl_ff.has_left   ? left_ff : '0;
      right_v = s1_ctrl_ff.has_right  ? (byp_b_hit_ff ? byp_b_data_ff : rd_b.recent) : '0;
      elem_v  = s1_ctrl_ff.is_element ? s1_elem_ff : '0;
      m       = smax(smax(smax(center_v, up_v), smax(left_v, right_v)),
                     smax(elem_v, '0));

      wr_en          = s1_fire && s1_ctrl_ff.is_element;
      wr_data.older  = s1_ctrl_ff.emit ? center_v : word_a.older;
      wr_data.recent = s1_elem_ff;

      rsp_valid_in             = s1_valid_ff && s1_ctrl_ff.emit;
      rsp_data_in.result_value = RESULT_WIDTH'($unsigned(m));
      rsp_data_in.frame_last   = s1_ctrl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         if (!s1_valid_ff || out_ready) begin
            s1_valid_ff <= accept && (item_ctrl.is_element || item_ctrl.emit);
         end
         if (out_ready) begin
            rsp_valid_ff <= rsp_valid_in;
         end
         if (s1_fire && s1_ctrl_ff.emit) begin
            left_ff <= center_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff    <= item_ctrl;
         s1_addr_ff    <= item_addr;
         s1_elem_ff    <= req_data.element;
         // the beat leaving now writes the ram in the cycle we read it
         byp_a_hit_ff  <= wr_en && (s1_addr_ff == item_addr);
         byp_b_hit_ff  <= wr_en && (s1_addr_ff == item_addr_next);
         byp_a_data_ff <= wr_data;
         byp_b_data_ff <= wr_data.recent;
      end
      if (out_ready && rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/cnmf_checker.sv =====
// port-level checks of the cross neighbourhood max filter and its bind
// uses cnmf_pkg and cross_neighbourhood_max_filter_core_defines.svh
`include "cross_neighbourhood_max_filter_core_defines.svh"

module cnmf_checker import cnmf_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data
);

   // a held response beat keeps its payload
   `CNMF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "response beat changed while stalled")

   // requests back up only behind a stalled response
   `CNMF_ASSERT(a_stall_cause, (!rsp_valid || !rsp_stall) |-> !req_stall, "request stalled with response path free")

   // a fresh result always comes from a taken request beat, passed through the s1 and response registers
   `CNMF_ASSERT(a_rsp_origin, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "result without a matching request beat")

   // reset empties the pipeline
   `CNMF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

bind cross_neighbourhood_max_filter_core cnmf_checker u_cnmf_checker (.*);

// ===== tb/tb.sv =====
// self-checking testbench for cross_neighbourhood_max_filter_core
// streams frames and drain beats, predicts every filtered cell, checks each result beat
// depends on cnmf_pkg and the core under src
`timescale 1ns / 1ps

module tb;
   import cnmf_pkg::*;

   localparam int MAX_SIZE = 128;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CFG_WIDTH-1:0] csr_wdata = '0;

   cross_neighbourhood_max_filter_core #(
      .MAX_SIZE(MAX_SIZE)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // stimulus and expectations
   req_type stimulus_beats[$];
   rsp_type expected_maxima[$];
   int      beats_queued = 0;
   int      errors = 0;
   bit      beat_taken = 1'b0;

   // idling controls, written by the sequence
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_len = 0;
   int hold_count = 0;

   // shadow of the filter state
   shortint older_line [MAX_SIZE];
   shortint recent_line [MAX_SIZE];
   logic [CFG_WIDTH-1:0] size_reg;
   int row_pos, col_pos, drain_left;
   int left_hold;
   int span, cur_row, cur_col, out_col, peak, center, incoming;
   rsp_type predicted, wanted;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // predictor and scoreboard, all at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         size_reg   = CFG_WIDTH'(RESET_SIZE);
         row_pos    = 0;
         col_pos    = 0;
         drain_left = 0;
         left_hold  = 0;
         beat_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_maxima.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got value %0d last %0b",
                        $time, rsp_data.result_value, rsp_data.frame_last);
            end else begin
               wanted = expected_maxima.pop_front();
               if (rsp_data.result_value !== wanted.result_value ||
                   rsp_data.frame_last !== wanted.frame_last) begin
                  errors++;
                  $display("%0t: mismatch, expected value %0d last %0b, got value %0d last %0b",
                           $time, wanted.result_value, wanted.frame_last,
                           rsp_data.result_value, rsp_data.frame_last);
               end
            end
         end

         // a size write restarts the frame, line data stays
         if (csr_we) begin
            size_reg   = csr_wdata;
            row_pos    = 0;
            col_pos    = 0;
            drain_left = 0;
         end

         beat_taken = req_valid && !req_stall;
         if (beat_taken) begin
            span = (size_reg == 0) ? 1 : ((size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg));
            if (req_data.kind == KIND_DRAIN) begin
               if (drain_left != 0 && drain_left <= span) begin
                  out_col = span - drain_left;
                  peak = 0;
                  if (recent_line[out_col] > peak) peak = recent_line[out_col];
                  if (span >= 2 && older_line[out_col] > peak) peak = older_line[out_col];
                  if (out_col > 0 && recent_line[out_col-1] > peak)
                     peak = recent_line[out_col-1];
                  if (out_col + 1 < span && recent_line[out_col+1] > peak)
                     peak = recent_line[out_col+1];
                  drain_left--;
                  predicted.result_value = RESULT_WIDTH'(peak);
                  predicted.frame_last   = (drain_left == 0);
                  expected_maxima.push_back(predicted);
               end
            end else begin
               incoming = shortint'(req_data.element);
               cur_row  = row_pos;
               cur_col  = col_pos;
               // an element drops whatever is left of the last row
               drain_left = 0;
               if (cur_row >= span || cur_col >= span) begin
                  cur_row = 0;
                  cur_col = 0;
               end
               if (cur_row >= 1) begin
                  center = recent_line[cur_col];
                  peak = 0;
                  if (center > peak) peak = center;
                  if (cur_row >= 2 && older_line[cur_col] > peak) peak = older_line[cur_col];
                  if (cur_col > 0 && left_hold > peak) peak = left_hold;
                  if (cur_col + 1 < span && recent_line[cur_col+1] > peak)
                     peak = recent_line[cur_col+1];
                  if (incoming > peak) peak = incoming;
                  left_hold = center;
                  older_line[cur_col] = shortint'(center);
                  predicted.result_value = RESULT_WIDTH'(peak);
                  predicted.frame_last   = 1'b0;
                  expected_maxima.push_back(predicted);
               end
               recent_line[cur_col] = shortint'(incoming);
               cur_col++;
               if (cur_col >= span) begin
                  cur_col = 0;
                  cur_row++;
                  if (cur_row >= span) begin
                     cur_row    = 0;
                     drain_left = span;
                  end
               end
               row_pos = cur_row;
               col_pos = cur_col;
            end
         end
      end
   end

   // request driver: a beat stays put until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (stimulus_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= stimulus_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure, with one long hold-off when asked
   always @(negedge clock) begin
      if (hold_count < hold_len) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic push_beat(input kind_type k, input int value);
      req_type b;
      b.kind    = k;
      b.element = ELEMENT_WIDTH'(value);
      stimulus_beats.push_back(b);
      beats_queued++;
   endtask

   function automatic int pick_element();
      int v;
      case ($urandom_range(9))
         0:       v = -32768;
         1:       v = 32767;
         2:       v = 0;
         3, 4, 5: v = int'($urandom_range(40)) - 20;
         default: v = int'(shortint'($urandom()));
      endcase
      return v;
   endfunction

   // one sequence: mostly whole frames with their drain, some broken ones
   task automatic queue_frame(input int n);
      int pick, count;
      pick = $urandom_range(99);
      if (pick < 92) begin
         count = (pick < 84) ? n * n : $urandom_range(n * n - 1);
         repeat (count) push_beat(KIND_ELEMENT, pick_element());
      end
      if (pick < 70) count = n;
      else if (pick < 78) count = $urandom_range(n - 1);
      else if (pick < 84) count = n + $urandom_range(1, 3);
      else count = $urandom_range(0, 4);
      repeat (count) push_beat(KIND_DRAIN, pick_element());
   endtask

   task automatic settle();
      while (stimulus_beats.size() != 0 || req_valid || expected_maxima.size() != 0)
         @(negedge clock);
      // element beats that release nothing may still be in the pipe
      repeat (8) @(negedge clock);
   endtask

   task automatic write_size(input int v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CFG_WIDTH'(v);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int p, n, start, random_count, guard;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // drain with nothing pending, then part of a first row at the reset size
      push_beat(KIND_DRAIN, 0);
      push_beat(KIND_ELEMENT, 12);
      push_beat(KIND_ELEMENT, -7);
      push_beat(KIND_ELEMENT, 32767);
      settle();

      // single-row matrix: all results come from drains
      write_size(1);
      push_beat(KIND_ELEMENT, 32767);
      push_beat(KIND_DRAIN, 0);
      push_beat(KIND_DRAIN, -1);
      push_beat(KIND_ELEMENT, -32768);
      push_beat(KIND_ELEMENT, 5);
      push_beat(KIND_DRAIN, 0);
      settle();

      // 2x2 frame, a partial drain cut short by the next frame
      write_size(2);
      push_beat(KIND_ELEMENT, -32768);
      push_beat(KIND_ELEMENT, 32767);
      push_beat(KIND_ELEMENT, -1);
      push_beat(KIND_ELEMENT, 0);
      push_beat(KIND_DRAIN, 0);
      push_beat(KIND_ELEMENT, -5);
      push_beat(KIND_ELEMENT, -3);
      push_beat(KIND_ELEMENT, -2);
      push_beat(KIND_ELEMENT, -32768);
      push_beat(KIND_DRAIN, 0);
      push_beat(KIND_DRAIN, 0);
      push_beat(KIND_DRAIN, 0);
      settle();

      random_count = 0;
      p = 0;
      while (p < 8 || random_count < 1400) begin
         case (p % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 67; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         if (p == 2) begin
            // oversize write acts as the largest matrix: first row and part of the second
            write_size(255);
            repeat (MAX_SIZE + 60) push_beat(KIND_ELEMENT, pick_element());
            repeat (2) push_beat(KIND_DRAIN, pick_element());
         end else if (p == 6) begin
            // largest size, frame abandoned after a few rows
            write_size(MAX_SIZE);
            repeat (MAX_SIZE * 2 + 40) push_beat(KIND_ELEMENT, pick_element());
            repeat (2) push_beat(KIND_DRAIN, pick_element());
         end else begin
            if (p == 3) n = 0;
            else if ($urandom_range(9) == 0) n = $urandom_range(9, 16);
            else n = $urandom_range(1, 8);
            write_size(n);
            if (n == 0) n = 1;
            // long receiver hold-off while the sender keeps offering
            if (p == 4) hold_len = 400;
            start = beats_queued;
            repeat ($urandom_range(3, 6)) queue_frame(n);
            random_count += beats_queued - start;
         end
         settle();
         p++;
      end

      guard = 0;
      while ((stimulus_beats.size() != 0 || req_valid || expected_maxima.size() != 0) &&
             guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (expected_maxima.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, expected_maxima.size());
      if (errors == 0 && expected_maxima.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("tb: failure");
      $finish;
   end

endmodule
